// ===== hdl/eflps_pkg.sv =====
// Shared types and constants of the earliest-free-port list scheduler.
// Used by the channel interfaces and by every module of the block.
package eflps_pkg;

   localparam int JOB_W      = 6;
   localparam int ARR_W      = 16;
   localparam int TIME_W     = 23;
   localparam int SUM_W      = 32;
   localparam int PEN_W      = 40;
   localparam int PORT_OUT_W = 4;
   localparam int CFG_W      = 5;

   localparam int DEFAULT_PORT_COUNT = 16;

   localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;
   localparam logic [TIME_W-1:0] TIME_MAX  = 23'h7F_FFFF;
   localparam logic [SUM_W-1:0]  SUM_MAX   = 32'hFFFF_FFFF;
   localparam logic [PEN_W-1:0]  PEN_MAX   = 40'hFF_FFFF_FFFF;

   localparam int WAIT_SCALE   = 100;
   localparam int URGENT_SCALE = 600;

   // One job as it travels from the front part to the back part.
   typedef struct packed {
      logic [JOB_W-1:0] job_index;
      logic [ARR_W-1:0] arrival_time;
      logic [ARR_W-1:0] job_duration;
      logic             urgent;
      logic             last_job;
   } job_type;

endpackage

// ===== hdl/eflps_if.sv =====
// Valid/ready channel interfaces for job requests and schedule responses.
// Depends on eflps_pkg for field widths.
interface eflps_req_if;
   logic                           valid;
   logic                           ready;
   logic [eflps_pkg::JOB_W-1:0]    job_index;
   logic [eflps_pkg::ARR_W-1:0]    arrival_time;
   logic [eflps_pkg::ARR_W-1:0]    job_duration;
   logic                           urgent;
   logic                           last_job;

   modport source (output valid, job_index, arrival_time, job_duration, urgent, last_job,
                   input ready);
   modport sink   (input valid, job_index, arrival_time, job_duration, urgent, last_job,
                   output ready);
endinterface

interface eflps_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [eflps_pkg::JOB_W-1:0]      job_index_out;
   logic [eflps_pkg::PORT_OUT_W-1:0] port_chosen;
   logic [eflps_pkg::TIME_W-1:0]     start_time;
   logic [eflps_pkg::TIME_W-1:0]     end_time;
   logic [eflps_pkg::TIME_W-1:0]     wait_time;
   logic                             sequence_done;
   logic [eflps_pkg::PEN_W-1:0]      penalty_x100;

   modport source (output valid, job_index_out, port_chosen, start_time, end_time,
                   wait_time, sequence_done, penalty_x100, input ready);
   modport sink   (input valid, job_index_out, port_chosen, start_time, end_time,
                   wait_time, sequence_done, penalty_x100, output ready);
endinterface

// ===== hdl/eflps_front.sv =====
// Front part: configuration register, request intake and a two-entry job queue.
// Depends on eflps_pkg and eflps_req_if.
module eflps_front #(
   parameter int  PORT_COUNT = eflps_pkg::DEFAULT_PORT_COUNT,
   localparam int PIDX_W     = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [eflps_pkg::CFG_W-1:0]   csr_write_data,
   eflps_req_if.sink                     req_if,
   output eflps_pkg::job_type            q_job,
   output logic [PIDX_W-1:0]             q_last_port,
   output logic                          q_valid,
   input  logic                          q_ready
);

   localparam logic [6:0] PortCountW = 7'(PORT_COUNT);

   logic [eflps_pkg::CFG_W-1:0] ports_ff, ports_in;
   eflps_pkg::job_type          job_mem_ff [2];
   logic [PIDX_W-1:0]           last_mem_ff [2];
   logic                        wr_ptr_ff, wr_ptr_in;
   logic                        rd_ptr_ff, rd_ptr_in;
   logic [1:0]                  count_ff, count_in;

   logic                        push, pop;
   logic [6:0]                  n_ext;
   logic [PIDX_W-1:0]           last_port;
   eflps_pkg::job_type          in_job;

   // Highest port index to search, with the port count clamped to one..PORT_COUNT.
   always_comb begin
      n_ext = {2'b00, ports_ff};
      if (n_ext == 7'd0) begin
         last_port = '0;
      end else if (n_ext > PortCountW) begin
         last_port = PIDX_W'(PORT_COUNT - 1);
      end else begin
         last_port = PIDX_W'(n_ext - 7'd1);
      end
   end

   always_comb begin
      in_job.job_index    = req_if.job_index;
      in_job.arrival_time = req_if.arrival_time;
      in_job.job_duration = req_if.job_duration;
      in_job.urgent       = req_if.urgent;
      in_job.last_job     = req_if.last_job;
   end

   assign req_if.ready = (count_ff != 2'd2);
   assign q_valid      = (count_ff != 2'd0);
   assign q_job        = job_mem_ff[rd_ptr_ff];
   assign q_last_port  = last_mem_ff[rd_ptr_ff];

   assign push = req_if.valid && req_if.ready;
   assign pop  = q_valid && q_ready;

   always_comb begin
      ports_in  = csr_write_enable ? csr_write_data : ports_ff;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ports_ff  <= eflps_pkg::CFG_RESET;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         ports_ff  <= ports_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         job_mem_ff[wr_ptr_ff]  <= in_job;
         last_mem_ff[wr_ptr_ff] <= last_port;
      end
   end

endmodule

// ===== hdl/eflps_back.sv =====
// Back part: port scan, schedule update, penalty arithmetic and response register.
// Depends on eflps_pkg and eflps_rsp_if.
module eflps_back #(
   parameter int  PORT_COUNT = eflps_pkg::DEFAULT_PORT_COUNT,
   localparam int PIDX_W     = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  eflps_pkg::job_type   q_job,
   input  logic [PIDX_W-1:0]    q_last_port,
   input  logic                 q_valid,
   output logic                 q_ready,
   eflps_rsp_if.source          rsp_if
);

   localparam int TW  = eflps_pkg::TIME_W;
   localparam int SW  = eflps_pkg::SUM_W;
   localparam int PW  = eflps_pkg::PEN_W;
   localparam int AW  = SW + 7;
   localparam int BW  = SW + 10;
   localparam int TOT = BW + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_UPDATE, S_PEN_MUL, S_PEN_SUM, S_OUT
   } state_type;

   state_type             state_ff, state_in;
   eflps_pkg::job_type    job_ff, job_in;
   logic [PIDX_W-1:0]     last_port_ff, last_port_in;
   logic [PIDX_W-1:0]     idx_ff, idx_in;
   logic [PIDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [TW-1:0]         best_time_ff, best_time_in;
   logic [TW-1:0]         free_ff [PORT_COUNT];
   logic [TW-1:0]         free_in [PORT_COUNT];
   logic [SW-1:0]         wait_sum_ff, wait_sum_in;
   logic [SW-1:0]         urg_sum_ff, urg_sum_in;
   logic [TW-1:0]         makespan_ff, makespan_in;
   logic [TW-1:0]         start_ff, start_in;
   logic [TW-1:0]         end_ff, end_in;
   logic [TW-1:0]         wait_ff, wait_in;
   logic [AW-1:0]         prod_a_ff, prod_a_in;
   logic [BW-1:0]         prod_b_ff, prod_b_in;
   logic [PW-1:0]         pen_ff, pen_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [eflps_pkg::JOB_W-1:0]       rsp_job_ff, rsp_job_in;
   logic [eflps_pkg::PORT_OUT_W-1:0]  rsp_port_ff, rsp_port_in;
   logic [TW-1:0]                     rsp_start_ff, rsp_start_in;
   logic [TW-1:0]                     rsp_end_ff, rsp_end_in;
   logic [TW-1:0]                     rsp_wait_ff, rsp_wait_in;
   logic                              rsp_done_ff, rsp_done_in;
   logic [PW-1:0]                     rsp_pen_ff, rsp_pen_in;

   logic [TW-1:0]         scan_time;
   logic [TW-1:0]         arr_ext;
   logic [TW-1:0]         start_c;
   logic [TW:0]           end_sum;
   logic [TW-1:0]         end_c;
   logic [TW-1:0]         wait_c;
   logic [SW:0]           ws_sum, us_sum;
   logic [TOT-1:0]        total;
   logic [PIDX_W+3:0]     port_wide;
   logic                  out_free;

   assign scan_time = free_ff[idx_ff];
   assign q_ready   = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign port_wide = {4'b0000, best_idx_ff};

   always_comb begin
      arr_ext = {{(TW - eflps_pkg::ARR_W){1'b0}}, job_ff.arrival_time};
      start_c = (best_time_ff > arr_ext) ? best_time_ff : arr_ext;
      end_sum = {1'b0, start_c} + {{(TW + 1 - eflps_pkg::ARR_W){1'b0}}, job_ff.job_duration};
      end_c   = end_sum[TW] ? eflps_pkg::TIME_MAX : end_sum[TW-1:0];
      wait_c  = start_c - arr_ext;
      ws_sum  = {1'b0, wait_sum_ff} + {{(SW + 1 - TW){1'b0}}, wait_c};
      us_sum  = {1'b0, urg_sum_ff} + {{(SW + 1 - TW){1'b0}}, wait_c};
      total   = TOT'(prod_a_ff) + TOT'(prod_b_ff) + TOT'(makespan_ff);
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      last_port_in = last_port_ff;
      idx_in       = idx_ff;
      best_idx_in  = best_idx_ff;
      best_time_in = best_time_ff;
      free_in      = free_ff;
      wait_sum_in  = wait_sum_ff;
      urg_sum_in   = urg_sum_ff;
      makespan_in  = makespan_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      wait_in      = wait_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      pen_in       = pen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_job_in   = rsp_job_ff;
      rsp_port_in  = rsp_port_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_wait_in  = rsp_wait_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_pen_in   = rsp_pen_ff;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               job_in       = q_job;
               last_port_in = q_last_port;
               idx_in       = '0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            // Strict compare keeps the lowest port on a tie.
            if (idx_ff == '0 || scan_time < best_time_ff) begin
               best_idx_in  = idx_ff;
               best_time_in = scan_time;
            end
            if (idx_ff == last_port_ff) begin
               state_in = S_UPDATE;
            end else begin
               idx_in = idx_ff + PIDX_W'(1);
            end
         end
         S_UPDATE: begin
            start_in             = start_c;
            end_in               = end_c;
            wait_in              = wait_c;
            free_in[best_idx_ff] = end_c;
            if (end_c > makespan_ff) begin
               makespan_in = end_c;
            end
            wait_sum_in = ws_sum[SW] ? eflps_pkg::SUM_MAX : ws_sum[SW-1:0];
            if (job_ff.urgent) begin
               urg_sum_in = us_sum[SW] ? eflps_pkg::SUM_MAX : us_sum[SW-1:0];
            end
            state_in = job_ff.last_job ? S_PEN_MUL : S_OUT;
         end
         S_PEN_MUL: begin
            prod_a_in = AW'(wait_sum_ff) * AW'(eflps_pkg::WAIT_SCALE);
            prod_b_in = BW'(urg_sum_ff) * BW'(eflps_pkg::URGENT_SCALE);
            state_in  = S_PEN_SUM;
         end
         S_PEN_SUM: begin
            pen_in   = (|total[TOT-1:PW]) ? eflps_pkg::PEN_MAX : total[PW-1:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_job_in   = job_ff.job_index;
               rsp_port_in  = port_wide[3:0];
               rsp_start_in = start_ff;
               rsp_end_in   = end_ff;
               rsp_wait_in  = wait_ff;
               rsp_done_in  = job_ff.last_job;
               rsp_pen_in   = job_ff.last_job ? pen_ff : '0;
               if (job_ff.last_job) begin
                  for (int i = 0; i < PORT_COUNT; i++) begin
                     free_in[i] = '0;
                  end
                  wait_sum_in = '0;
                  urg_sum_in  = '0;
                  makespan_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PORT_COUNT; i++) begin
            free_ff[i] <= '0;
         end
         wait_sum_ff  <= '0;
         urg_sum_ff   <= '0;
         makespan_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         free_ff      <= free_in;
         wait_sum_ff  <= wait_sum_in;
         urg_sum_ff   <= urg_sum_in;
         makespan_ff  <= makespan_in;
      end
      job_ff       <= job_in;
      last_port_ff <= last_port_in;
      idx_ff       <= idx_in;
      best_idx_ff  <= best_idx_in;
      best_time_ff <= best_time_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      wait_ff      <= wait_in;
      prod_a_ff    <= prod_a_in;
      prod_b_ff    <= prod_b_in;
      pen_ff       <= pen_in;
      rsp_job_ff   <= rsp_job_in;
      rsp_port_ff  <= rsp_port_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_wait_ff  <= rsp_wait_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_pen_ff   <= rsp_pen_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.job_index_out = rsp_job_ff;
   assign rsp_if.port_chosen   = rsp_port_ff;
   assign rsp_if.start_time    = rsp_start_ff;
   assign rsp_if.end_time      = rsp_end_ff;
   assign rsp_if.wait_time     = rsp_wait_ff;
   assign rsp_if.sequence_done = rsp_done_ff;
   assign rsp_if.penalty_x100  = rsp_pen_ff;

endmodule

// ===== hdl/earliest_free_port_list_scheduler_top.sv =====
// A request passes through the front queue, the back part's port scan, the schedule update
// and the response register; the job marked last also passes the penalty multiply and sum
// states. The back part takes a new job only when idle, and its scan reads one port free time per cycle.
// The front queue holds two requests, so intake continues while the back part works.
// Reset (synchronous, active high) clears all port free times, the wait sums, the
// makespan and both handshakes, and sets the port count register to sixteen.
module earliest_free_port_list_scheduler_top #(
   parameter int PORT_COUNT = eflps_pkg::DEFAULT_PORT_COUNT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [eflps_pkg::CFG_W-1:0]   csr_write_data,
   eflps_req_if.sink                     req_if,
   eflps_rsp_if.source                   rsp_if
);

   localparam int PIDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

   // Jobs queued by the front part, each with the highest port index to search.
   eflps_pkg::job_type  q_job;
   logic [PIDX_W-1:0]   q_last_port;
   logic                q_valid;
   logic                q_ready;

   // The front part owns the port count register and classifies each transaction
   // with the clamped search range when it enters the queue.
   eflps_front #(
      .PORT_COUNT (PORT_COUNT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_if           (req_if),
      .q_job            (q_job),
      .q_last_port      (q_last_port),
      .q_valid          (q_valid),
      .q_ready          (q_ready)
   );

   // The back part scans for the earliest free port, books the job, keeps the
   // sums and produces the penalty on the last job of a sequence.
   eflps_back #(
      .PORT_COUNT (PORT_COUNT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_job       (q_job),
      .q_last_port (q_last_port),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .rsp_if      (rsp_if)
   );

endmodule
